// ===== rtl/band_cholesky_factorizer_defines.svh =====
// Assertion helpers for the band Cholesky factorizer
`ifndef BAND_CHOLESKY_FACTORIZER_DEFINES_SVH
`define BAND_CHOLESKY_FACTORIZER_DEFINES_SVH

// Check that an implication holds at every edge outside reset
`define BCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcf check failed");

// Check an implication with the consequent in the next cycle
`define BCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcf check failed");

`endif

// ===== rtl/bcf_pkg.sv =====
package bcf_pkg;

  localparam int unsigned MaxOrder     = 64;
  localparam int unsigned MaxBandwidth = 7;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned FracBits     = 16;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpFactor = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] RegUpper = 2'd0;
  localparam logic [1:0] RegOrder = 2'd1;
  localparam logic [1:0] RegBand  = 2'd2;

  typedef enum logic [1:0] {
    AluIdle,
    AluSqrt,
    AluDiv,
    AluMac
  } alu_state_e;

  typedef enum logic [3:0] {
    SIdle,
    SColStart,
    SDiagWait,
    SSqrt,
    SSqrtWait,
    SDivRead,
    SDivWait,
    SDivRun,
    SDivWrite,
    SUpdRead,
    SUpdWait,
    SUpdRun,
    SUpdWrite,
    SOut
  } seq_state_e;

  // Unit request from the sequencer
  typedef struct packed {
    logic       start;
    alu_state_e op;
  } alu_req_t;

endpackage

// ===== rtl/bcf_alu.sv =====
// Shared arithmetic unit: bit-serial square root, restoring divide and
// multiply-subtract with truncation and saturation.
module bcf_alu import bcf_pkg::*; #(
  parameter int unsigned ValW = ValueWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  alu_req_t        req_i,
  input  logic [ValW-1:0] a_i,
  input  logic [ValW-1:0] b_i,
  input  logic [ValW-1:0] c_i,
  output logic            done_o,
  output logic [ValW-1:0] res_o
);
  localparam int unsigned WW = 2 * ValW + 2;
  localparam int unsigned CW = $clog2(WW + 1);
  localparam logic signed [ValW:0] VMax = {2'b00, {(ValW - 1){1'b1}}};
  localparam logic signed [ValW:0] VMin = {2'b11, {(ValW - 1){1'b0}}};

  alu_state_e st_q, st_d;
  logic [WW-1:0] x_q, x_d, r_q, r_d, bit_q, bit_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic [ValW-1:0] res_q, res_d;
  logic done_q, done_d;
  logic [WW-1:0] trial;
  logic signed [2*ValW-1:0] prod;
  logic signed [2*ValW-1:0] pt;
  logic signed [2*ValW:0] diff;
  logic [WW-1:0] qmag;
  logic signed [WW:0] qs;

  function automatic logic [ValW-1:0] sat_f(input logic signed [WW:0] v);
    logic [ValW-1:0] r;
    if (v > $signed({{(WW-ValW){1'b0}}, VMax})) r = VMax[ValW-1:0];
    else if (v < $signed({{(WW-ValW){1'b1}}, VMin})) r = VMin[ValW-1:0];
    else r = v[ValW-1:0];
    return r;
  endfunction

  always_comb begin
    trial = r_q + bit_q;
    prod  = $signed(b_i) * $signed(c_i);
    pt    = prod[2*ValW-1] ? -((-prod) >>> FracBits) : (prod >>> FracBits);
    diff  = $signed({{(ValW+1){a_i[ValW-1]}}, a_i}) - $signed({pt[2*ValW-1], pt});
    qmag  = x_q;
    qs    = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  // Sequence one operation
  always_comb begin
    st_d = st_q; x_d = x_q; r_d = r_q; bit_d = bit_q; den_d = den_q;
    cnt_d = cnt_q; neg_d = neg_q; res_d = res_q; done_d = 1'b0;
    unique case (st_q)
      AluIdle: begin
        if (req_i.start) begin
          unique case (req_i.op)
            AluSqrt: begin
              st_d = AluSqrt;
              x_d = WW'({1'b0, a_i}) << FracBits;
              r_d = '0;
              bit_d = WW'(1) << (2 * ((WW - 2) / 2));
              cnt_d = CW'((WW - 2) / 2 + 1);
            end
            AluDiv: begin
              st_d = AluDiv;
              neg_d = a_i[ValW-1];
              r_d = '0;
              x_d = WW'(a_i[ValW-1] ? -$signed({a_i[ValW-1], a_i})
                                    : $signed({1'b0, a_i})) << FracBits;
              den_d = WW'(b_i);
              cnt_d = CW'(WW);
            end
            AluMac: begin
              res_d = sat_f((WW+1)'(diff));
              done_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      AluSqrt: begin
        if (cnt_q == '0) begin
          res_d = sat_f($signed({1'b0, r_q}));
          done_d = 1'b1;
          st_d = AluIdle;
        end else begin
          if (x_q >= trial) begin
            x_d = x_q - trial;
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
          cnt_d = cnt_q - 1'b1;
        end
      end
      AluDiv: begin
        if (cnt_q == '0) begin
          res_d = sat_f(qs);
          done_d = 1'b1;
          st_d = AluIdle;
        end else begin
          if ({r_q[WW-2:0], x_q[WW-1]} >= den_q) begin
            r_d = {r_q[WW-2:0], x_q[WW-1]} - den_q;
            x_d = {x_q[WW-2:0], 1'b1};
          end else begin
            r_d = {r_q[WW-2:0], x_q[WW-1]};
            x_d = {x_q[WW-2:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: st_d = AluIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= AluIdle;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; r_q <= r_d; bit_q <= bit_d; den_q <= den_d;
    cnt_q <= cnt_d; neg_q <= neg_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

// ===== rtl/band_cholesky_factorizer.sv =====
// Band Cholesky factorizer, signed Q16.16.
// Input channel (in_valid_i/in_ready_o) carries op, band_row, column, value.
// Op 0 loads one band cell, op 1 factors the stored band matrix in place,
// op 2 reads one cell; op 3 is dropped. Ops 1 and 2 give one result item on
// the output channel (out_valid_o/out_ready_i): kind, read_value, status,
// fail_column. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) set
// upper_mode, order and bandwidth; the user must write them only while the
// block is idle, as the block does not enforce it. One item is in flight at
// a time; ready stays low until its result is taken. A load or a dropped op
// leaves the block idle, so loads stream back to back. A read passes through
// SSqrt, which registers the stored word as the result, then waits in SOut
// until taken. Factorization is bound by the shared arithmetic unit and the
// one-port band memory: per column it takes the square root of the diagonal,
// divides each off-diagonal element by it and updates each trailing element.
// Reset clears the control and configuration registers (upper mode, order 0,
// bandwidth 0); band memory is undefined until loaded.
// A stalled receiver holds the result register and blocks new input items.
module band_cholesky_factorizer import bcf_pkg::*; #(
  parameter int unsigned MAX_ORDER     = MaxOrder,
  parameter int unsigned MAX_BANDWIDTH = MaxBandwidth,
  parameter int unsigned VALUE_WIDTH   = ValueWidth,
  localparam int unsigned RW = (MAX_BANDWIDTH + 1 > 1) ? $clog2(MAX_BANDWIDTH + 1) : 1,
  localparam int unsigned CLW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [6:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [RW-1:0]                band_row_i,
  input  logic [CLW-1:0]               column_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic signed [VALUE_WIDTH-1:0] read_value_o,
  output logic                         status_o,
  output logic [6:0]                   fail_column_o
);
  `include "band_cholesky_factorizer_defines.svh"

  localparam int unsigned Rows  = MAX_BANDWIDTH + 1;
  localparam int unsigned Depth = Rows * MAX_ORDER;
  localparam int unsigned AW    = $clog2(Depth + 1);
  localparam int unsigned NW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned KW    = $clog2(MAX_BANDWIDTH + 2);
  localparam int unsigned VW    = VALUE_WIDTH;

  // Configuration registers
  logic upper_q;
  logic [6:0] order_q;
  logic [2:0] bw_q;
  logic [NW-1:0] n_eff;
  logic [KW-1:0] kd_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 1'b1;
      order_q <= '0;
      bw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegUpper: upper_q <= cfg_data_i[0];
        RegOrder: order_q <= cfg_data_i;
        RegBand:  bw_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign n_eff  = (32'(order_q) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_q);
  assign kd_eff = (32'(bw_q) > MAX_BANDWIDTH) ? KW'(MAX_BANDWIDTH) : KW'(bw_q);

  // Band memory
  logic [VW-1:0] mem [Depth];
  logic [VW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [VW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr[$clog2(Depth)-1:0]] <= mem_wdata;
    rdata_q <= mem[mem_addr[$clog2(Depth)-1:0]];
  end

  function automatic logic [AW-1:0] addr_f(input logic [KW-1:0] row,
                                           input logic [NW-1:0] col);
    return AW'(32'(col) * Rows + 32'(row));
  endfunction

  // Sequencer state
  seq_state_e st_q, st_d;
  logic [NW-1:0] j_q, j_d;
  logic [KW-1:0] p_q, p_d, q_q, q_d, kn_q, kn_d;
  logic [VW-1:0] r_q, r_d;
  logic [VW-1:0] x_q [Rows];
  logic [VW-1:0] xw;
  logic          xwe;
  logic [RW-1:0] xidx;
  logic [1:0]    op_q, op_d;
  logic          in_q, in_d;
  logic          out_v_q, out_v_d;
  logic          kind_q, kind_d, stat_q, stat_d;
  logic [VW-1:0] rv_q, rv_d;
  logic [6:0]    fc_q, fc_d;
  logic          last_status_q, last_status_d;
  logic [KW-1:0] row_sel;
  logic [NW-1:0] col_sel;

  alu_req_t      req;
  logic [VW-1:0] alu_a, alu_b, alu_c, alu_res;
  logic          alu_done;

  bcf_alu #(.ValW(VW)) u_alu (
    .clk_i, .rst_ni, .req_i(req), .a_i(alu_a), .b_i(alu_b), .c_i(alu_c),
    .done_o(alu_done), .res_o(alu_res)
  );

  logic [KW-1:0] drow;
  logic [NW:0]   rem;
  assign drow = upper_q ? kd_eff : '0;
  assign rem  = (NW+1)'(n_eff) - (NW+1)'(j_q) - 1'b1;

  // Cell of element p of column j while dividing, else trailing cell (p, q)
  always_comb begin
    if (st_q inside {SDivRead, SDivWait, SDivRun, SDivWrite}) begin
      row_sel = upper_q ? KW'(kd_eff - 1'b1 - p_q) : KW'(p_q + 1'b1);
      col_sel = upper_q ? NW'(j_q + 1'b1 + NW'(p_q)) : j_q;
    end else begin
      row_sel = upper_q ? KW'(kd_eff + p_q - q_q) : KW'(p_q - q_q);
      col_sel = NW'(j_q + 1'b1 + NW'(q_q));
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        unique case (op_i)
          OpFactor: st_d = SColStart;
          OpRead:   st_d = SSqrt;
          default:  st_d = SIdle;
        endcase
      end
      SColStart: st_d = (j_q == n_eff) ? SOut : SDiagWait;
      SDiagWait: st_d = SSqrt;
      SSqrt: begin
        if (op_q == OpRead) st_d = SOut;
        else if ($signed(rdata_q) <= 0) st_d = SOut;
        else st_d = SSqrtWait;
      end
      SSqrtWait: if (alu_done) st_d = (kn_q == '0) ? SColStart : SDivRead;
      SDivRead:  st_d = SDivWait;
      SDivWait:  st_d = SDivRun;
      SDivRun:   if (alu_done) st_d = SDivWrite;
      SDivWrite: st_d = (p_q + 1'b1 == kn_q) ? SUpdRead : SDivRead;
      SUpdRead:  st_d = SUpdWait;
      SUpdWait:  st_d = SUpdRun;
      SUpdRun:   if (alu_done) st_d = SUpdWrite;
      SUpdWrite: begin
        if (upper_q ? (p_q == q_q && q_q + 1'b1 == kn_q)
                    : (p_q + 1'b1 == kn_q && q_q + 1'b1 == kn_q)) st_d = SColStart;
        else st_d = SUpdRead;
      end
      SOut: if (out_v_q && out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    j_d = j_q; p_d = p_q; q_d = q_q; kn_d = kn_q; r_d = r_q; op_d = op_q;
    in_d = in_q; out_v_d = out_v_q; kind_d = kind_q; stat_d = stat_q;
    rv_d = rv_q; fc_d = fc_q; last_status_d = last_status_q;
    mem_we = 1'b0; mem_wdata = value_i;
    mem_addr = addr_f(row_sel, col_sel);
    req = '{start: 1'b0, op: AluIdle};
    alu_a = rdata_q; alu_b = r_q; alu_c = '0;
    xwe = 1'b0; xidx = p_q[RW-1:0]; xw = alu_res;
    unique case (st_q)
      SIdle: begin
        mem_addr = addr_f(KW'(band_row_i), NW'(column_i));
        op_d = op_i;
        in_d = (32'(band_row_i) < Rows) && (32'(column_i) < MAX_ORDER);
        j_d = '0;
        if (in_valid_i && in_ready_o && op_i == OpLoad && in_d) mem_we = 1'b1;
      end
      SColStart: begin
        mem_addr = addr_f(drow, j_q);
        kn_d = (rem > (NW+1)'(kd_eff)) ? kd_eff : KW'(rem);
        p_d = '0; q_d = '0;
        if (j_q == n_eff) begin
          fc_d = '0; stat_d = 1'b0; last_status_d = 1'b0;
          kind_d = 1'b1; rv_d = '0; out_v_d = 1'b1;
        end
      end
      SDiagWait: mem_addr = addr_f(drow, j_q);
      SSqrt: begin
        if (op_q == OpRead) begin
          kind_d = 1'b0; rv_d = in_q ? rdata_q : '0; stat_d = 1'b0; fc_d = '0;
          out_v_d = 1'b1;
        end else if ($signed(rdata_q) <= 0) begin
          kind_d = 1'b1; rv_d = '0; stat_d = 1'b1; last_status_d = 1'b1;
          fc_d = 7'(j_q + 1'b1); out_v_d = 1'b1;
        end else begin
          req = '{start: 1'b1, op: AluSqrt};
        end
      end
      SSqrtWait: begin
        mem_addr = addr_f(drow, j_q);
        mem_wdata = alu_res;
        if (alu_done) begin
          mem_we = 1'b1; r_d = alu_res;
          if (kn_q == '0) j_d = j_q + 1'b1;
        end
      end
      SDivRead, SDivWait, SDivRun: ;
      SDivWrite: begin
        mem_we = 1'b1; mem_wdata = x_q[p_q[RW-1:0]];
        if (p_q + 1'b1 == kn_q) begin
          p_d = '0; q_d = '0;
        end else p_d = p_q + 1'b1;
      end
      SUpdRead, SUpdWait: ;
      SUpdRun: begin
        alu_a = rdata_q; alu_b = x_q[p_q[RW-1:0]]; alu_c = x_q[q_q[RW-1:0]];
      end
      SUpdWrite: begin
        mem_we = 1'b1; mem_wdata = rv_q;
        if (upper_q) begin
          if (p_q == q_q) begin
            p_d = '0; q_d = q_q + 1'b1;
            if (q_q + 1'b1 == kn_q) j_d = j_q + 1'b1;
          end else p_d = p_q + 1'b1;
        end else begin
          if (p_q + 1'b1 == kn_q) begin
            q_d = q_q + 1'b1; p_d = q_q + 1'b1;
            if (q_q + 1'b1 == kn_q) j_d = j_q + 1'b1;
          end else p_d = p_q + 1'b1;
        end
      end
      SOut: if (out_ready_i) out_v_d = 1'b0;
      default: ;
    endcase
    // Kick the unit on entering a run state, capture its result on done
    if (st_q == SDivWait) req = '{start: 1'b1, op: AluDiv};
    if (st_q == SUpdWait) begin
      req = '{start: 1'b1, op: AluMac};
      alu_b = x_q[p_q[RW-1:0]]; alu_c = x_q[q_q[RW-1:0]];
    end
    if (st_q == SDivRun && alu_done) xwe = 1'b1;
    if (st_q == SUpdRun && alu_done) rv_d = alu_res;
  end

  // Keep each scaled off-diagonal element for the trailing update
  always_ff @(posedge clk_i) begin
    if (xwe) x_q[xidx] <= xw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      out_v_q <= 1'b0;
      last_status_q <= 1'b0;
    end else begin
      st_q <= st_d;
      out_v_q <= out_v_d;
      last_status_q <= last_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; p_q <= p_d; q_q <= q_d; kn_q <= kn_d; r_q <= r_d;
    op_q <= op_d; in_q <= in_d; kind_q <= kind_d; stat_q <= stat_d;
    rv_q <= rv_d; fc_q <= fc_d;
  end

  assign in_ready_o    = (st_q == SIdle);
  assign out_valid_o   = out_v_q;
  assign kind_o        = kind_q;
  assign read_value_o  = rv_q;
  assign status_o      = stat_q;
  assign fail_column_o = fc_q;

  `BCF_ASSERT_IMP(a_ready_out, out_valid_o, !in_ready_o)
  `BCF_ASSERT_IMP(a_fc_status, out_valid_o && kind_o, (fail_column_o != 7'd0) == status_o)
  `BCF_ASSERT_IMP(a_read_zero, out_valid_o && !kind_o, !status_o && fail_column_o == 7'd0)
  `BCF_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o)
endmodule

// ===== verif/bcf_checker.sv =====
module bcf_checker import bcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         op_i,
  input  logic [2:0]         band_row_i,
  input  logic [5:0]         column_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               kind_i,
  input  logic signed [31:0] read_value_i,
  input  logic               status_i,
  input  logic [6:0]         fail_column_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BandRows = MaxBandwidth + 1;
  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] read_value;
    logic               status;
    logic [6:0]         fail_column;
  } band_result_t;

  longint       band_mem [BandRows*MaxOrder];
  logic         upper_q;
  logic [6:0]   order_q;
  logic [2:0]   bw_q;
  band_result_t results_due [$];

  assign pending_o = results_due.size();

  function automatic longint clip(longint v);
    if (v > ValMax) return ValMax;
    if (v < ValMin) return ValMin;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int slot(int r, int c);
    return c * BandRows + r;
  endfunction

  // Factor the stored band in place; give the one-based failing column or 0
  function automatic int factor_band();
    int     n, kd, kn, drow, a;
    longint d, root;
    longint xs [BandRows];
    n  = (order_q > MaxOrder) ? MaxOrder : order_q;
    kd = bw_q;
    for (int j = 0; j < n; j++) begin
      drow = upper_q ? kd : 0;
      d = band_mem[slot(drow, j)];
      if (d <= 0) return j + 1;
      root = longint'(int_root(longint'(d) << FracBits));
      band_mem[slot(drow, j)] = clip(root);
      kn = n - j - 1;
      if (kn > kd) kn = kd;
      for (int p = 0; p < kn; p++) begin
        a = upper_q ? slot(kd - 1 - p, j + 1 + p) : slot(p + 1, j);
        xs[p] = clip((band_mem[a] * 65536) / root);
        band_mem[a] = xs[p];
      end
      for (int q = 0; q < kn; q++) begin
        for (int p = 0; p < kn; p++) begin
          if (upper_q ? (p > q) : (p < q)) continue;
          a = upper_q ? slot(kd + p - q, j + 1 + q) : slot(p - q, j + 1 + q);
          band_mem[a] = clip(band_mem[a] - (xs[p] * xs[q]) / 65536);
        end
      end
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    band_result_t want, got;
    int fc;
    if (!rst_ni) begin
      upper_q <= 1'b1;
      order_q <= '0;
      bw_q    <= '0;
      results_due.delete();
      fail_count_o <= 0;
    end else begin
      // Compare a taken result with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got = '{kind_i, read_value_i, status_i, fail_column_i};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %p actual %p", $time, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // Predict from an accepted item
      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OpLoad: band_mem[slot(band_row_i, column_i)] = clip(longint'(value_i));
          OpFactor: begin
            fc = factor_band();
            results_due.push_back('{1'b1, 32'sd0, fc != 0, 7'(fc)});
          end
          OpRead: results_due.push_back(
            '{1'b0, 32'(band_mem[slot(band_row_i, column_i)]), 1'b0, 7'd0});
          default: ;
        endcase
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegUpper: upper_q <= cfg_data_i[0];
          RegOrder: order_q <= cfg_data_i;
          RegBand:  bw_q    <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== verif/testbench.sv =====
module testbench import bcf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [6:0]        cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i = '0;
  logic [2:0]        band_row_i = '0;
  logic [5:0]        column_i = '0;
  logic signed [31:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              kind_o;
  logic signed [31:0] read_value_o;
  logic              status_o;
  logic [6:0]        fail_column_o;
  int                pending, fail_count;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;
  int                item_count = 0;

  band_cholesky_factorizer i_dut (.*);

  bcf_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .band_row_i, .column_i, .value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o),
    .read_value_i(read_value_o), .status_i(status_o), .fail_column_i(fail_column_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the receiver at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any accepted item or taken result
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [2:0] r, logic [5:0] c, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    band_row_i <= r;
    column_i   <= c;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    item_count++;
  endtask

  // Drain results and let a trailing load settle before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_regs(logic upper, logic [6:0] n, logic [2:0] kd);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegUpper;
    cfg_data_i <= {6'd0, upper};
    @(posedge clk_i);
    cfg_idx_i <= RegOrder;
    cfg_data_i <= n;
    @(posedge clk_i);
    cfg_idx_i <= RegBand;
    cfg_data_i <= {4'd0, kd};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load a random band, diagonally heavy unless spoiled; factor; read some back
  task automatic run_matrix(logic upper, int n, int kd, bit spoil);
    int drow, bad_col;
    logic [31:0] v;
    settle();
    write_regs(upper, 7'(n), 3'(kd));
    drow = upper ? kd : 0;
    bad_col = $urandom_range(n > 0 ? n - 1 : 0);
    for (int c = 0; c < n; c++) begin
      for (int r = 0; r <= kd; r++) begin
        if (r == drow) begin
          v = (spoil && c == bad_col) ? -$urandom_range(65536) :
              (kd + 1) * 131072 + $urandom_range(131071);
        end else begin
          v = $urandom_range(131072) - 65536;
        end
        send_item(OpLoad, 3'(r), 6'(c), v);
      end
      if ($urandom_range(19) == 0) send_item(OpUnused, 3'($urandom), 6'($urandom), $urandom);
    end
    send_item(OpFactor, 3'($urandom), 6'($urandom), $urandom);
    repeat ($urandom_range(8)) begin
      send_item(OpRead, 3'($urandom_range(kd)), 6'($urandom_range(n > 0 ? n - 1 : 0)),
                $urandom);
    end
    // Noise: a stray read anywhere in storage
    if ($urandom_range(3) == 0) send_item(OpRead, 3'($urandom), 6'($urandom), $urandom);
  endtask

  initial begin
    int n, kd;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every cell so no read or factorization touches an unwritten one
    for (int c = 0; c < MaxOrder; c++) begin
      for (int r = 0; r <= MaxBandwidth; r++) send_item(OpLoad, 3'(r), 6'(c), $urandom);
    end

    // Directed: value extremes, unused op, zero order, oversize order
    send_item(OpLoad, 3'd7, 6'd63, 32'h8000_0000);
    send_item(OpRead, 3'd7, 6'd63, 32'h0);
    send_item(OpLoad, 3'd0, 6'd0, 32'h7fff_ffff);
    send_item(OpRead, 3'd0, 6'd0, 32'hffff_ffff);
    send_item(OpUnused, 3'd7, 6'd63, 32'hffff_ffff);
    send_item(OpRead, 3'd7, 6'd63, 32'h0);
    send_item(OpFactor, 3'd0, 6'd0, 32'h0);
    settle();
    write_regs(1'b0, 7'd127, 3'd7);
    send_item(OpFactor, 3'd0, 6'd0, 32'h0);
    run_matrix(1'b1, 64, 7, 1'b0);
    run_matrix(1'b0, 64, 7, 1'b0);
    run_matrix(1'b1, 1, 0, 1'b0);
    run_matrix(1'b0, 5, 2, 1'b1);
    run_matrix(1'b1, 0, 3, 1'b0);

    // Random matrices through the idling phases
    for (int ph = 0; item_count < 1800; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      n = ($urandom_range(29) == 0) ? 64 : $urandom_range(12);
      kd = $urandom_range(7);
      run_matrix(1'($urandom), n, kd, $urandom_range(5) == 0);
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
